// ----- sv/css_pkg.sv -----
// css_pkg: widths, limits, sequencer states and control structs for the
// streaming cosine similarity block. No dependencies.
`default_nettype none

package css_pkg;

  localparam int unsigned ELEM_W     = 16;  // element width, Q1.15
  localparam int unsigned ACC_W      = 40;  // accumulator width
  localparam int unsigned OPND_W     = 21;  // shared multiplier operand width
  localparam int unsigned PROD_W     = 42;  // shared multiplier product width
  localparam int unsigned ALU_W      = 42;  // shared adder/subtractor width
  localparam int unsigned ROOT_W     = 20;  // integer root of a 40-bit sum
  localparam int unsigned ROOT_STEPS = 20;  // one result bit per step
  localparam int unsigned DIV_STEPS  = 16;  // one quotient bit per step
  localparam int unsigned Q_W        = 16;  // quotient width
  localparam int unsigned STEP_W     = 5;

  localparam logic [ACC_W-1:0] SQ_MAX    = {ACC_W{1'b1}};
  localparam logic [ACC_W-1:0] DOT_MAX   = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] DOT_MIN   = {1'b1, {(ACC_W-1){1'b0}}};
  // Highest power of four below 2^ACC_W.
  localparam logic [ACC_W-1:0] ROOT_BIT0 = {2'b01, {(ACC_W-2){1'b0}}};

  localparam logic [Q_W-1:0]    Q_NEG_LIM = {1'b1, {(Q_W-1){1'b0}}};
  localparam logic [ELEM_W-1:0] SIM_MAX   = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic [ELEM_W-1:0] SIM_MIN   = {1'b1, {(ELEM_W-1){1'b0}}};

  // Product terms formed per pair, by step.
  localparam logic [STEP_W-1:0] TERM_AB = STEP_W'(0);
  localparam logic [STEP_W-1:0] TERM_AA = STEP_W'(1);
  localparam logic [STEP_W-1:0] TERM_BB = STEP_W'(2);

  localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(ROOT_STEPS - 1);
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DIV_STEPS - 1);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_MUL   = 11'b000_0000_0010,
    ST_ACC   = 11'b000_0000_0100,
    ST_TEST  = 11'b000_0000_1000,
    ST_ROOTA = 11'b000_0001_0000,
    ST_ROOTB = 11'b000_0010_0000,
    ST_NMUL  = 11'b000_0100_0000,
    ST_ABS   = 11'b000_1000_0000,
    ST_CHK   = 11'b001_0000_0000,
    ST_DIV   = 11'b010_0000_0000,
    ST_OUT   = 11'b100_0000_0000
  } css_state_e;

  typedef struct packed {
    css_state_e        state;
    logic [STEP_W-1:0] step;
    logic              step_last;
  } css_ctrl_t;

  typedef struct packed {
    logic in_xfer;
    logic last_pair;
    logic zero_sum;
    logic quot_sat;
    logic out_free;
  } css_stat_t;

endpackage

`default_nettype wire

// ----- sv/css_if.sv -----
// css_in_if / css_out_if: valid/ready channels carrying element pairs and
// similarity results. Depends on css_pkg.
`default_nettype none

interface css_in_if import css_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] element_a;
  logic signed [ELEM_W-1:0] element_b;
  logic                     last_pair;

  modport source (output valid, output element_a, output element_b, output last_pair,
                  input ready);
  modport sink   (input valid, input element_a, input element_b, input last_pair,
                  output ready);
endinterface

interface css_out_if import css_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] similarity;
  logic                     zero_norm;

  modport source (output valid, output similarity, output zero_norm, input ready);
  modport sink   (input valid, input similarity, input zero_norm, output ready);
endinterface

`default_nettype wire

// ----- sv/cosine_similarity_stream.sv -----
// Streaming cosine similarity: each pair's three products go through one
// multiplier and one adder before input is ready again.
// A final pair adds two 20-step square roots, a norm product and a 16-step
// divide (no divide when the quotient saturates, neither roots nor divide
// for a zero norm); loading the output register then frees input.
// Reset (async, active low) clears the sequencer, accumulators and output valid.
`default_nettype none

module cosine_similarity_stream import css_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  css_in_if.sink    in_i,
  css_out_if.source out_o
);

  css_ctrl_t ctrl;
  css_stat_t stat;

  // Latched input pair.
  logic signed [ELEM_W-1:0] a_q, b_q;
  logic                     last_q;

  // Shared multiplier and its product register. The norm product stays in
  // prod_q and serves as the divisor.
  logic signed [OPND_W-1:0] mul_x, mul_y;
  logic signed [PROD_W-1:0] mul_p, prod_q;
  logic [ACC_W-1:0]         den;

  // Shared adder/subtractor.
  logic signed [ALU_W-1:0] alu_x, alu_y, alu_r;
  logic                    alu_sub, alu_ge;

  // Accumulators.
  logic signed [ACC_W-1:0] dot_q;
  logic [ACC_W-1:0]        sqa_q, sqb_q;
  logic [ACC_W-1:0]        dot_sat, sq_sat;

  // Root, divide and result registers.
  logic [ACC_W-1:0]  rx_q, root_q, bit_q, root_try, root_nxt;
  logic [ROOT_W-1:0] na_q, nb_q;
  logic [ACC_W-1:0]  mag_q, rem_q;
  logic [ACC_W:0]    rem_sh;
  logic [Q_W-1:0]    quo_q;
  logic              zn_q, sat_q;
  logic              out_valid_q, zno_q, out_load;
  logic [ELEM_W-1:0] sim_q, sim_val;
  logic              neg;

  css_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  css_mul u_mul (
    .a_i (mul_x),
    .b_i (mul_y),
    .p_o (mul_p)
  );

  css_alu u_alu (
    .x_i   (alu_x),
    .y_i   (alu_y),
    .sub_i (alu_sub),
    .r_o   (alu_r),
    .ge_o  (alu_ge)
  );

  // Handshake: take a pair only when the sequencer is idle.
  assign in_i.ready = (ctrl.state == ST_IDLE);
  assign out_load   = (ctrl.state == ST_OUT) && stat.out_free;

  assign stat.in_xfer   = in_i.valid && in_i.ready;
  assign stat.last_pair = last_q;
  assign stat.zero_sum  = (sqa_q == '0) || (sqb_q == '0);
  assign stat.quot_sat  = alu_ge;
  assign stat.out_free  = !out_valid_q || out_o.ready;

  assign out_o.valid      = out_valid_q;
  assign out_o.similarity = sim_q;
  assign out_o.zero_norm  = zno_q;

  assign den = prod_q[ACC_W-1:0];

  // Multiplier operands: a*b, a*a, b*b per pair, then normA*normB.
  always_comb begin
    mul_x = '0;
    mul_y = '0;
    unique case (ctrl.state)
      ST_MUL: begin
        unique case (ctrl.step)
          TERM_AB: begin
            mul_x = OPND_W'(a_q);
            mul_y = OPND_W'(b_q);
          end
          TERM_AA: begin
            mul_x = OPND_W'(a_q);
            mul_y = OPND_W'(a_q);
          end
          default: begin
            mul_x = OPND_W'(b_q);
            mul_y = OPND_W'(b_q);
          end
        endcase
      end
      ST_NMUL: begin
        mul_x = {1'b0, na_q};
        mul_y = {1'b0, nb_q};
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  // Root step: trial value is root|bit, since root holds no bits below 2*bit.
  assign root_try = root_q | bit_q;
  assign root_nxt = alu_ge ? ((root_q >> 1) | bit_q) : (root_q >> 1);

  // Divide step: shift in the numerator's only live low bit on the first step.
  assign rem_sh = {rem_q, (ctrl.step == '0) ? mag_q[0] : 1'b0};

  // Adder operands per state.
  always_comb begin
    alu_x   = '0;
    alu_y   = '0;
    alu_sub = 1'b1;
    unique case (ctrl.state)
      ST_ACC: begin
        alu_sub = 1'b0;
        alu_y   = prod_q;
        unique case (ctrl.step)
          TERM_AB: alu_x = ALU_W'(dot_q);
          TERM_AA: alu_x = {2'b00, sqa_q};
          default: alu_x = {2'b00, sqb_q};
        endcase
      end
      ST_ROOTA, ST_ROOTB: begin
        alu_x = {2'b00, rx_q};
        alu_y = {2'b00, root_try};
      end
      ST_ABS: begin
        alu_x = '0;
        alu_y = ALU_W'(dot_q);
      end
      ST_CHK: begin
        // Quotient reaches 2^16 exactly when |dot| >= 2*den.
        alu_x = {2'b00, mag_q};
        alu_y = {1'b0, den, 1'b0};
      end
      ST_DIV: begin
        alu_x = {1'b0, rem_sh};
        alu_y = {2'b00, den};
      end
      default: begin
        alu_x   = '0;
        alu_y   = '0;
        alu_sub = 1'b1;
      end
    endcase
  end

  // Saturate the sums: dot to signed 40 bits, squares to unsigned 40 bits.
  always_comb begin
    if ((alu_r[ALU_W-1:ACC_W-1] == '0) || (alu_r[ALU_W-1:ACC_W-1] == '1)) begin
      dot_sat = alu_r[ACC_W-1:0];
    end else begin
      dot_sat = alu_r[ALU_W-1] ? DOT_MIN : DOT_MAX;
    end
    sq_sat = (alu_r[ALU_W-1:ACC_W] != '0) ? SQ_MAX : alu_r[ACC_W-1:0];
  end

  // Final Q1.15 value: sign from the dot product, magnitude from the quotient.
  assign neg = dot_q[ACC_W-1];
  always_comb begin
    priority if (zn_q) begin
      sim_val = '0;
    end else if (sat_q) begin
      sim_val = neg ? SIM_MIN : SIM_MAX;
    end else if (neg) begin
      sim_val = (quo_q > Q_NEG_LIM) ? SIM_MIN : ELEM_W'(~quo_q + Q_W'(1));
    end else begin
      sim_val = quo_q[Q_W-1] ? SIM_MAX : ELEM_W'(quo_q);
    end
  end

  // Control state and accumulators.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      dot_q       <= '0;
      sqa_q       <= '0;
      sqb_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      if (out_load) begin
        // Clear for the next vector pair.
        dot_q <= '0;
        sqa_q <= '0;
        sqb_q <= '0;
      end else if (ctrl.state == ST_ACC) begin
        unique case (ctrl.step)
          TERM_AB: dot_q <= dot_sat;
          TERM_AA: sqa_q <= sq_sat;
          default: sqb_q <= sq_sat;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (stat.in_xfer) begin
      a_q    <= in_i.element_a;
      b_q    <= in_i.element_b;
      last_q <= in_i.last_pair;
    end

    if ((ctrl.state == ST_MUL) || (ctrl.state == ST_NMUL)) begin
      prod_q <= mul_p;
    end

    unique case (ctrl.state)
      ST_TEST: begin
        zn_q   <= stat.zero_sum;
        sat_q  <= 1'b0;
        rx_q   <= sqa_q;
        root_q <= '0;
        bit_q  <= ROOT_BIT0;
      end
      ST_ROOTA, ST_ROOTB: begin
        if (ctrl.step_last) begin
          if (ctrl.state == ST_ROOTA) begin
            na_q <= root_nxt[ROOT_W-1:0];
          end else begin
            nb_q <= root_nxt[ROOT_W-1:0];
          end
          // Reload for the second root; harmless after it.
          rx_q   <= sqb_q;
          root_q <= '0;
          bit_q  <= ROOT_BIT0;
        end else begin
          if (alu_ge) begin
            rx_q <= alu_r[ACC_W-1:0];
          end
          root_q <= root_nxt;
          bit_q  <= bit_q >> 2;
        end
      end
      ST_ABS: begin
        mag_q <= neg ? alu_r[ACC_W-1:0] : dot_q;
      end
      ST_CHK: begin
        sat_q <= alu_ge;
        rem_q <= {1'b0, mag_q[ACC_W-1:1]};
        quo_q <= '0;
      end
      ST_DIV: begin
        rem_q <= alu_ge ? alu_r[ACC_W-1:0] : rem_sh[ACC_W-1:0];
        quo_q <= {quo_q[Q_W-2:0], alu_ge};
      end
      default: begin
      end
    endcase

    if (out_load) begin
      sim_q <= sim_val;
      zno_q <= zn_q;
    end
  end

`ifndef SYNTHESIS
  a_valid_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(ctrl.state == ST_OUT))
    else $error("result raised outside the output state");

  a_zero_norm_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && zno_q) |-> (sim_q == '0))
    else $error("zero-norm result carries a nonzero similarity");

  a_acc_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> ((dot_q == '0) && (sqa_q == '0) && (sqb_q == '0)))
    else $error("accumulators not cleared after a result");

  a_root_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((ctrl.state == ST_ROOTA) || (ctrl.state == ST_ROOTB)) |->
      (ctrl.step < STEP_W'(ROOT_STEPS)))
    else $error("root step count out of range");
`endif

endmodule

`default_nettype wire

// ----- sv/css_mul.sv -----
// css_mul: shared signed multiplier for element products and the norm product.
// Depends on css_pkg.
`default_nettype none

module css_mul import css_pkg::*; (
  input  wire logic signed [OPND_W-1:0] a_i,
  input  wire logic signed [OPND_W-1:0] b_i,
  output logic signed [PROD_W-1:0]      p_o
);

  assign p_o = a_i * b_i;

endmodule

`default_nettype wire

// ----- sv/css_alu.sv -----
// css_alu: shared add/subtract unit for accumulation, root and divide steps.
// Depends on css_pkg.
`default_nettype none

module css_alu import css_pkg::*; (
  input  wire logic signed [ALU_W-1:0] x_i,
  input  wire logic signed [ALU_W-1:0] y_i,
  input  wire logic                    sub_i,
  output logic signed [ALU_W-1:0]      r_o,
  output logic                         ge_o
);

  assign r_o  = sub_i ? (x_i - y_i) : (x_i + y_i);
  // Non-negative difference: x >= y.
  assign ge_o = ~r_o[ALU_W-1];

endmodule

`default_nettype wire

// ----- sv/css_seq.sv -----
// css_seq: sequencer that steps the shared multiplier and adder through
// accumulation, two square roots, the norm product and the divide.
// Depends on css_pkg.
`default_nettype none

module css_seq import css_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire css_stat_t stat_i,
  output css_ctrl_t      ctrl_o
);

  css_state_e        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              step_last;

  always_comb begin
    step_last = 1'b0;
    unique case (state_q)
      ST_ACC:             step_last = (step_q == TERM_BB);
      ST_ROOTA, ST_ROOTB: step_last = (step_q == ROOT_LAST);
      ST_DIV:             step_last = (step_q == DIV_LAST);
      default:            step_last = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (stat_i.in_xfer) begin
          state_d = ST_MUL;
          step_d  = '0;
        end
      end
      ST_MUL: state_d = ST_ACC;
      ST_ACC: begin
        if (step_last) begin
          step_d  = '0;
          state_d = stat_i.last_pair ? ST_TEST : ST_IDLE;
        end else begin
          step_d  = step_q + STEP_W'(1);
          state_d = ST_MUL;
        end
      end
      ST_TEST: begin
        step_d  = '0;
        state_d = stat_i.zero_sum ? ST_OUT : ST_ROOTA;
      end
      ST_ROOTA: begin
        if (step_last) begin
          step_d  = '0;
          state_d = ST_ROOTB;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_ROOTB: begin
        if (step_last) begin
          step_d  = '0;
          state_d = ST_NMUL;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_NMUL: state_d = ST_ABS;
      ST_ABS:  state_d = ST_CHK;
      ST_CHK: begin
        step_d  = '0;
        state_d = stat_i.quot_sat ? ST_OUT : ST_DIV;
      end
      ST_DIV: begin
        if (step_last) begin
          state_d = ST_OUT;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_OUT: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        step_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign ctrl_o = '{state: state_q, step: step_q, step_last: step_last};

endmodule

`default_nettype wire

// ----- verif/cosine_similarity_stream_tb.sv -----
// Self-checking testbench for cosine_similarity_stream: element pairs go in over
// css_in_if, similarity results are checked against a local predictor.
// Depends on css_pkg, css_in_if, css_out_if and the block itself.
`timescale 1ns / 1ps

module cosine_similarity_stream_tb;
  import css_pkg::*;

  // Accumulator limits at the block's widths.
  localparam longint DOT_HI = (longint'(1) << (ACC_W - 1)) - 1;
  localparam longint DOT_LO = -(longint'(1) << (ACC_W - 1));
  localparam longint SQ_HI  = (longint'(1) << ACC_W) - 1;

  localparam logic signed [ELEM_W-1:0] ELEM_MAX = SIM_MAX;
  localparam logic signed [ELEM_W-1:0] ELEM_MIN = SIM_MIN;

  localparam int unsigned RANDOM_ITEMS = 250;
  localparam int unsigned QUIET_ITEMS  = 100;  // tail of the run with no idling
  localparam int unsigned TAIL_CYCLES  = 80;   // a little beyond the slowest result

  typedef struct packed {
    logic signed [ELEM_W-1:0] similarity;
    logic                     zero_norm;
  } sim_result_t;

  logic clk_i;
  logic rst_ni;

  css_in_if  in_if ();
  css_out_if out_if ();

  cosine_similarity_stream i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Predictor state: running sums of the vector currently streaming in.
  longint      dot_sum;
  longint      sq_sum_a;
  longint      sq_sum_b;
  sim_result_t pending_results[$];

  int unsigned fail_count;
  bit          idle_on;

  // 8 ns clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #8_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Floor integer square root, bit by bit from the highest power of four.
  function automatic longint floor_root(input longint x);
    longint res;
    longint probe;
    res   = 0;
    probe = longint'(1) << 62;
    while (probe > x) probe = probe >>> 2;
    while (probe != 0) begin
      if (x >= res + probe) begin
        x   = x - (res + probe);
        res = (res >>> 1) + probe;
      end else begin
        res = res >>> 1;
      end
      probe = probe >>> 2;
    end
    return res;
  endfunction

  // Fold one accepted pair into the running sums; on the final pair, queue the
  // expected similarity and clear the sums.
  task automatic accumulate_pair(input logic signed [ELEM_W-1:0] a,
                                 input logic signed [ELEM_W-1:0] b,
                                 input logic last);
    longint      ea;
    longint      eb;
    longint      norm_a;
    longint      norm_b;
    longint      mag;
    longint      quot;
    sim_result_t res;
    ea = a;
    eb = b;
    // Saturate the dot product at the signed limits, squares at the unsigned one.
    dot_sum = dot_sum + ea * eb;
    if (dot_sum > DOT_HI) dot_sum = DOT_HI;
    if (dot_sum < DOT_LO) dot_sum = DOT_LO;
    sq_sum_a = sq_sum_a + ea * ea;
    if (sq_sum_a > SQ_HI) sq_sum_a = SQ_HI;
    sq_sum_b = sq_sum_b + eb * eb;
    if (sq_sum_b > SQ_HI) sq_sum_b = SQ_HI;
    if (!last) return;

    if (sq_sum_a == 0 || sq_sum_b == 0) begin
      res.similarity = '0;
      res.zero_norm  = 1'b1;
    end else begin
      norm_a = floor_root(sq_sum_a);
      norm_b = floor_root(sq_sum_b);
      mag    = (dot_sum < 0) ? -dot_sum : dot_sum;
      quot   = (mag << 15) / (norm_a * norm_b);
      // Floor roots can push the magnitude past one: clamp to Q1.15.
      if (dot_sum < 0) begin
        res.similarity = (quot > 32768) ? ELEM_MIN : ELEM_W'(-quot);
      end else begin
        res.similarity = (quot > 32767) ? ELEM_MAX : ELEM_W'(quot);
      end
      res.zero_norm = 1'b0;
    end
    pending_results.push_back(res);
    dot_sum  = 0;
    sq_sum_a = 0;
    sq_sum_b = 0;
  endtask

  // Send one pair. Entered and left at a falling edge; valid stays high on exit
  // so back-to-back pairs need no extra step.
  task automatic send_pair(input logic signed [ELEM_W-1:0] a,
                           input logic signed [ELEM_W-1:0] b,
                           input logic last);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.element_a <= a;
    in_if.element_b <= b;
    in_if.last_pair <= last;
    // Hold until the transfer happens.
    do @(posedge clk_i); while (!in_if.ready);
    accumulate_pair(a, b, last);
    @(negedge clk_i);
  endtask

  // Drop valid and hold off until every queued result has come out.
  task automatic wait_results_drained();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // Mostly full range, with extremes, zero and small values mixed in.
  function automatic logic signed [ELEM_W-1:0] pick_element();
    case ($urandom_range(0, 9))
      0:       return ELEM_MIN;
      1:       return ELEM_MAX;
      2:       return '0;
      3, 4:    return ELEM_W'(int'($urandom_range(0, 15)) - 8);
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  // Single pairs at the corners of the range and at small values, where the result lands on the Q1.15 limits.
  task automatic test_extremes();
    send_pair(ELEM_MAX, ELEM_MAX, 1'b1);
    send_pair(ELEM_MIN, ELEM_MIN, 1'b1);
    send_pair(ELEM_MIN, ELEM_MAX, 1'b1);
    send_pair(ELEM_MAX, ELEM_MIN, 1'b1);
    send_pair(16'sd1, 16'sd1, 1'b1);
    send_pair(16'sd1, -16'sd1, 1'b1);
    send_pair(16'sh5555, 16'shAAAA, 1'b1);
  endtask

  // Either or both sums of squares zero: similarity forced to zero.
  task automatic test_zero_norm();
    send_pair('0, '0, 1'b1);
    send_pair('0, 16'sd5, 1'b1);
    send_pair(16'sd7, '0, 1'b1);
    send_pair('0, ELEM_MIN, 1'b0);
    send_pair('0, ELEM_MAX, 1'b1);
  endtask

  // Short vectors: orthogonal, and ones whose floor roots push past one.
  task automatic test_short_vectors();
    send_pair(16'sd1, '0, 1'b0);
    send_pair('0, 16'sd1, 1'b1);
    send_pair(16'sd3, 16'sd3, 1'b0);
    send_pair(16'sd1, 16'sd1, 1'b1);
    send_pair(16'sd3, -16'sd3, 1'b0);
    send_pair(16'sd1, -16'sd1, 1'b1);
    send_pair(16'sd1200, -16'sd300, 1'b0);
    send_pair(-16'sd4500, 16'sd17, 1'b0);
    send_pair(16'sd9, 16'sd22000, 1'b1);
  endtask

  // Vectors longer than the nominal maximum: both kinds of sum saturate.
  task automatic test_overlong();
    int unsigned k;
    // 1025 corner pairs fill the squares past 2^40 and the dot past 2^39.
    for (k = 0; k < 1025; k++) send_pair(ELEM_MIN, ELEM_MIN, k == 1024);
    // Opposite signs drive the dot product into its negative limit.
    for (k = 0; k < 520; k++) send_pair(ELEM_MIN, ELEM_MAX, k == 519);
  endtask

  // Random vectors: mostly well-formed with random lengths and content, the
  // rest noise with the last flag set at random.
  task automatic test_random_vectors(input int unsigned item_goal);
    int unsigned              sent;
    int unsigned              len;
    int unsigned              style;
    int unsigned              k;
    bit                       drained;
    bit                       noise;
    logic signed [ELEM_W-1:0] a;
    logic signed [ELEM_W-1:0] b;
    sent    = 0;
    drained = 1'b0;
    while (sent < item_goal) begin
      if (sent >= item_goal - QUIET_ITEMS) idle_on = 1'b0;
      // Once mid-run, let everything in flight come out before going on.
      if (!drained && sent >= item_goal / 2) begin
        wait_results_drained();
        drained = 1'b1;
      end
      noise = ($urandom_range(0, 9) >= 8);
      len   = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
      style = $urandom_range(0, 3);
      for (k = 0; k < len; k++) begin
        a = pick_element();
        case (style)
          0:       b = pick_element();
          1:       b = a;
          2:       b = -a;
          default: b = ELEM_W'(int'(a) + int'($urandom_range(0, 15)) - 8);
        endcase
        if (noise) send_pair(a, b, $urandom_range(0, 3) == 0);
        else       send_pair(a, b, k == len - 1);
      end
      sent += len;
    end
  endtask

  // Output side: accept results with random stall bursts, none in the quiet tail.
  initial begin
    out_if.ready = 1'b0;
    @(negedge clk_i);
    forever begin
      if (idle_on && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        @(negedge clk_i);
      end
    end
  end

  // Compare each transfer on the output with the oldest expected result.
  always @(posedge clk_i) begin
    sim_result_t exp_res;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: similarity %0d zero_norm %0b",
               out_if.similarity, out_if.zero_norm);
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_if.similarity !== exp_res.similarity) begin
          $error("similarity mismatch: expected %0d, actual %0d",
                 exp_res.similarity, out_if.similarity);
          fail_count++;
        end
        if (out_if.zero_norm !== exp_res.zero_norm) begin
          $error("zero_norm mismatch: expected %0b, actual %0b",
                 exp_res.zero_norm, out_if.zero_norm);
          fail_count++;
        end
      end
    end
  end

  // Main sequence: reset once, run each test in turn, drain, report.
  initial begin
    fail_count      = 0;
    idle_on         = 1'b1;
    dot_sum         = 0;
    sq_sum_a        = 0;
    sq_sum_b        = 0;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.element_a = '0;
    in_if.element_b = '0;
    in_if.last_pair = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_extremes();
    test_zero_norm();
    test_short_vectors();
    test_overlong();
    test_random_vectors(RANDOM_ITEMS);

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
